FILE: hdl/ttoi_pkg.sv
// shared types and constants for the base-n text to integer converter
`default_nettype none

package ttoi_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int SYM_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;

  localparam logic [SYM_W-1:0] CH_TAB_LO = 8'd9;
  localparam logic [SYM_W-1:0] CH_TAB_HI = 8'd13;
  localparam logic [SYM_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [SYM_W-1:0] CH_NUL    = 8'h00;

  localparam logic [63:0]        SYMBOLS_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0]        SYMBOLS_HIGH_RST = 64'h0000000000003938;
  localparam logic [RADIX_W-1:0] RADIX_RST        = 5'd10;

  typedef struct packed {
    logic [SYM_W-1:0] text_byte;
    logic             end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      table_invalid;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: hdl/ttoi_stream_if.sv
// valid/ready stream channel carrying one beat of payload
`default_nettype none

interface ttoi_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/text_to_integer_any_base_core.sv
// top level: text to integer converter with a configurable symbol table
// a result: the final beat is held in the input stage register and, once it advances, sets the result register
// throughput: one byte beat per cycle; the input stalls only while a result waits
// configuration is checked combinationally and the outcome is held in the table check register
// rst (synchronous, active high) restores the decimal table and clears the parse state
`default_nettype none

module text_to_integer_any_base_core (
  input  wire logic         clk,
  input  wire logic         rst,
  ttoi_stream_if.sink       in_ch,
  ttoi_stream_if.source     out_ch,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic      [63:0]  prdata,
  output logic              pready
);

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [1:0] REG_RADIX_LENGTH = 2'd2;

  localparam int NSYM = ttoi_pkg::MAX_SYMBOLS;
  localparam int SW   = ttoi_pkg::SYM_W;
  localparam int VW   = ttoi_pkg::VALUE_W;
  localparam int RW   = ttoi_pkg::RADIX_W;

  // configuration registers
  logic [63:0]   symbols_low;
  logic [63:0]   symbols_high;
  logic [RW-1:0] radix_length;
  logic          table_ok;
  logic          table_ok_next;

  // input stage
  logic               s1_valid;
  ttoi_pkg::in_beat_t s1_beat;
  logic               s1_advance;

  // parse state
  logic [1:0]    phase;
  logic          negative;
  logic [VW-1:0] accumulator;
  logic [1:0]    phase_next;
  logic          negative_next;
  logic [VW-1:0] accumulator_next;

  // result register
  logic                out_valid;
  ttoi_pkg::out_beat_t out_beat;

  logic [2*64-1:0]              sym_bits;
  logic [NSYM-1:0][SW-1:0]      sym;
  logic [RW-1:0]                used_len;
  logic [NSYM-1:0]              sym_hit;
  logic [ttoi_pkg::DIGIT_W-1:0] digit;
  logic                         is_space;
  logic [SW-1:0]                cur;
  logic [1:0]                   ph_a;
  logic [1:0]                   ph_b;
  logic [VW-1:0]                result_value;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= ttoi_pkg::SYMBOLS_LOW_RST;
      symbols_high <= ttoi_pkg::SYMBOLS_HIGH_RST;
      radix_length <= ttoi_pkg::RADIX_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_SYMBOLS_LOW:  symbols_low  <= pwdata;
        REG_SYMBOLS_HIGH: symbols_high <= pwdata;
        REG_RADIX_LENGTH: radix_length <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SYMBOLS_LOW:  prdata = symbols_low;
      REG_SYMBOLS_HIGH: prdata = symbols_high;
      REG_RADIX_LENGTH: prdata = {{(64-RW){1'b0}}, radix_length};
      default:          prdata = '0;
    endcase
  end

  assign sym_bits = {symbols_high, symbols_low};

  always_comb begin
    for (int k = 0; k < NSYM; k++) begin
      sym[k] = sym_bits[k*SW +: SW];
    end
  end

  assign used_len = (radix_length > RW'(NSYM)) ? RW'(NSYM) : radix_length;

  // table check from the configuration registers, registered every cycle
  always_comb begin
    table_ok_next = (radix_length >= RW'(2)) && (radix_length <= RW'(NSYM));
    for (int i = 0; i < NSYM; i++) begin
      if (RW'(i) < radix_length) begin
        if (sym[i] == ttoi_pkg::CH_NUL || sym[i] == ttoi_pkg::CH_PLUS ||
            sym[i] == ttoi_pkg::CH_MINUS) begin
          table_ok_next = 1'b0;
        end
        for (int j = i + 1; j < NSYM; j++) begin
          if (RW'(j) < radix_length && sym[j] == sym[i]) begin
            table_ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    table_ok <= table_ok_next;
  end

  // handshake
  assign s1_advance  = s1_valid && (!s1_beat.end_of_text || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_beat <= in_ch.payload;
    end
  end

  // symbol lookup, lowest match wins
  assign cur = s1_beat.text_byte;

  always_comb begin
    for (int k = 0; k < NSYM; k++) begin
      sym_hit[k] = (RW'(k) < used_len) && (sym[k] == cur);
    end
  end

  always_comb begin
    digit = '0;
    for (int k = NSYM - 1; k >= 0; k--) begin
      if (sym_hit[k]) begin
        digit = ttoi_pkg::DIGIT_W'(k);
      end
    end
  end

  assign is_space = (cur >= ttoi_pkg::CH_TAB_LO && cur <= ttoi_pkg::CH_TAB_HI) ||
                    cur == ttoi_pkg::CH_SPACE;

  always_comb begin
    negative_next    = negative;
    accumulator_next = accumulator;
    ph_a             = (phase == PH_SPACE && !is_space) ? PH_SIGN : phase;
    ph_b             = ph_a;
    if (ph_a == PH_SIGN) begin
      if (cur == ttoi_pkg::CH_MINUS) begin
        negative_next = !negative;
      end else if (cur != ttoi_pkg::CH_PLUS) begin
        ph_b = PH_DIGIT;
      end
    end
    phase_next = ph_b;
    if (ph_b == PH_DIGIT) begin
      if (|sym_hit) begin
        accumulator_next = VW'(accumulator * {{(VW-RW){1'b0}}, used_len}) +
                           {{(VW-ttoi_pkg::DIGIT_W){1'b0}}, digit};
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  assign result_value = negative_next ? (VW'(0) - accumulator_next) : accumulator_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (s1_advance) begin
      if (s1_beat.end_of_text) begin
        phase       <= PH_SPACE;
        negative    <= 1'b0;
        accumulator <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_beat.end_of_text) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_beat.end_of_text) begin
      out_beat.value         <= table_ok ? result_value : '0;
      out_beat.table_invalid <= !table_ok;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_beat;

endmodule

`default_nettype wire

FILE: hdl/ttoi_checker.sv
// port-level checks for the text to integer converter, bound to the top level
`default_nettype none

module ttoi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        out_table_invalid
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_table_invalid))
    else $error("result beat changed while stalled");

  // an invalid table always reports zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_table_invalid |-> out_value == 32'd0)
    else $error("nonzero value with invalid table");

  // input backpressure only comes from a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // no result right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_to_integer_any_base_core ttoi_checker u_ttoi_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_value         (out_ch.payload.value),
  .out_table_invalid (out_ch.payload.table_invalid)
);

`default_nettype wire
